// ----- hw/rtl/kvs_pkg.sv -----
package kvs_pkg;

    localparam int KEY_IDX_W        = 6;
    localparam int KEY_TIME_W       = 24;
    localparam int VAL_W            = 32;
    localparam int KEY_COUNT_W      = 7;
    localparam int SEG_W            = 6;
    localparam int FRAC_W           = 16;
    localparam int N_COMP           = 3;
    localparam int STEP_CNT_W       = 4;
    localparam int DEFAULT_MAX_KEYS = 64;

    // Request type codes.
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic [KEY_TIME_W-1:0] t;
        logic [VAL_W-1:0]      x;
        logic [VAL_W-1:0]      y;
        logic [VAL_W-1:0]      z;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ADDR_ZERO,
        ADDR_LAST,
        ADDR_NEXT
    } addr_sel_t;

    typedef enum logic [1:0] {
        CLAMP_OFF,
        CLAMP_ON,
        CLAMP_NE
    } clamp_sel_t;

    typedef enum logic [1:0] {
        SEG_FIRST,
        SEG_LAST,
        SEG_SCAN
    } seg_sel_t;

    typedef enum logic [1:0] {
        COMP_X,
        COMP_Y,
        COMP_Z
    } comp_t;

    typedef struct packed {
        logic       key_wr;
        logic       smp_ld;
        logic       rd_en;
        addr_sel_t  addr_sel;
        logic       idx_inc;
        logic       a_ld;
        logic       b_ld;
        logic       clamp_ld;
        clamp_sel_t clamp_sel;
        logic       seg_ld;
        seg_sel_t   seg_sel;
        logic       div_init;
        logic       div_step;
        logic       mul_en;
        comp_t      mul_comp;
        logic       add_en;
        comp_t      add_comp;
        logic       out_ld;
    } dp_cmd_t;

    typedef struct packed {
        logic n_one;
        logic q_lt_rd;
        logic div_ok;
    } dp_stat_t;

endpackage

// ----- hw/rtl/kvs_if.sv -----
interface kvs_req_if
    import kvs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [KEY_IDX_W-1:0]    key_index;
    logic [KEY_TIME_W-1:0]   key_time;
    logic signed [VAL_W-1:0] value_x;
    logic signed [VAL_W-1:0] value_y;
    logic signed [VAL_W-1:0] value_z;
    logic [KEY_TIME_W-1:0]   query_time;

    modport source (
        output valid, req_type, key_index, key_time, value_x, value_y, value_z, query_time,
        input  ready
    );
    modport sink (
        input  valid, req_type, key_index, key_time, value_x, value_y, value_z, query_time,
        output ready
    );
endinterface

interface kvs_res_if
    import kvs_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic [SEG_W-1:0]        segment;
    logic                    clamped;

    modport source (
        output valid, out_x, out_y, out_z, segment, clamped,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, segment, clamped,
        output ready
    );
endinterface

interface kvs_cfg_if
    import kvs_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [KEY_COUNT_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

// ----- hw/rtl/kvs_ram.sv -----
module kvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/kvs_ctrl.sv -----
module kvs_ctrl
    import kvs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_type,
    output logic     req_ready,
    output logic     res_valid,
    input  logic     res_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_FIRST,
        S_LAST,
        S_SCAN,
        S_DIVI,
        S_DIV,
        S_MUL,
        S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  res_valid_reg, res_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.addr_sel   = ADDR_ZERO;
        cmd.clamp_sel  = CLAMP_OFF;
        cmd.seg_sel    = SEG_FIRST;
        cmd.mul_comp   = COMP_X;
        cmd.add_comp   = COMP_X;
        state_next     = state_reg;
        cnt_next       = '0;
        req_ready      = 1'b0;
        res_valid_next = res_valid_reg && !res_ready;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_type == REQ_SAMPLE)
                    begin
                        cmd.smp_ld = 1'b1;
                        state_next = S_RD0;
                    end
                    else
                    begin
                        cmd.key_wr = 1'b1;
                    end
                end
            end
            S_RD0:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = ADDR_ZERO;
                state_next   = S_FIRST;
            end
            S_FIRST:
            begin
                cmd.a_ld = 1'b1;
                cmd.b_ld = 1'b1;
                if (stat.n_one || stat.q_lt_rd)
                begin
                    cmd.clamp_ld  = 1'b1;
                    cmd.clamp_sel = stat.n_one ? CLAMP_NE : CLAMP_ON;
                    cmd.seg_ld    = 1'b1;
                    cmd.seg_sel   = SEG_FIRST;
                    cmd.div_init  = 1'b1;
                    state_next    = S_MUL;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_LAST;
                    state_next   = S_LAST;
                end
            end
            S_LAST:
            begin
                cmd.clamp_ld = 1'b1;
                if (!stat.q_lt_rd)
                begin
                    cmd.a_ld      = 1'b1;
                    cmd.b_ld      = 1'b1;
                    cmd.clamp_sel = CLAMP_ON;
                    cmd.seg_ld    = 1'b1;
                    cmd.seg_sel   = SEG_LAST;
                    cmd.div_init  = 1'b1;
                    state_next    = S_MUL;
                end
                else
                begin
                    cmd.clamp_sel = CLAMP_OFF;
                    cmd.rd_en     = 1'b1;
                    cmd.addr_sel  = ADDR_NEXT;
                    cmd.idx_inc   = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.q_lt_rd)
                begin
                    cmd.b_ld    = 1'b1;
                    cmd.seg_ld  = 1'b1;
                    cmd.seg_sel = SEG_SCAN;
                    state_next  = S_DIVI;
                end
                else
                begin
                    cmd.a_ld     = 1'b1;
                    cmd.rd_en    = 1'b1;
                    cmd.addr_sel = ADDR_NEXT;
                    cmd.idx_inc  = 1'b1;
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                state_next   = stat.div_ok ? S_DIV : S_MUL;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == STEP_CNT_W'(FRAC_W - 1))
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                // Multiply one component while the previous one is summed.
                cmd.mul_en   = (cnt_reg < STEP_CNT_W'(N_COMP));
                cmd.mul_comp = comp_t'(cnt_reg[1:0]);
                cmd.add_en   = (cnt_reg != '0);
                cmd.add_comp = comp_t'(cnt_reg[1:0] - 2'd1);
                if (cnt_reg == STEP_CNT_W'(N_COMP))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    cmd.out_ld     = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

// ----- hw/rtl/kvs_dp.sv -----
module kvs_dp
    import kvs_pkg::*;
#(
    parameter int MAX_KEYS = DEFAULT_MAX_KEYS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    output dp_stat_t                stat,
    input  logic                    cfg_valid,
    input  logic [KEY_COUNT_W-1:0]  cfg_data,
    input  logic [KEY_IDX_W-1:0]    key_index,
    input  logic [KEY_TIME_W-1:0]   key_time,
    input  logic [VAL_W-1:0]        value_x,
    input  logic [VAL_W-1:0]        value_y,
    input  logic [VAL_W-1:0]        value_z,
    input  logic [KEY_TIME_W-1:0]   query_time,
    output logic [VAL_W-1:0]        out_x,
    output logic [VAL_W-1:0]        out_y,
    output logic [VAL_W-1:0]        out_z,
    output logic [SEG_W-1:0]        segment,
    output logic                    clamped
);

    localparam int AW     = $clog2(MAX_KEYS);
    localparam int NW     = $clog2(MAX_KEYS + 1);
    localparam int PROD_W = VAL_W + 1 + FRAC_W + 1;

    logic [KEY_COUNT_W-1:0]   key_count_reg;
    logic [KEY_TIME_W-1:0]    q_reg;
    logic [NW-1:0]            n_reg, n_next;
    logic [AW-1:0]            idx_reg;
    logic [AW-1:0]            seg_reg;
    logic                     clamp_reg;
    entry_t                   a_reg, b_reg;
    logic [KEY_TIME_W-1:0]    rem_reg, span_reg;
    logic [FRAC_W-1:0]        quo_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [VAL_W-1:0]         res_reg [N_COMP];
    logic [VAL_W-1:0]         ox_reg, oy_reg, oz_reg;
    logic [SEG_W-1:0]         oseg_reg;
    logic                     oclamp_reg;

    logic                     ram_we;
    logic [AW-1:0]            raddr;
    logic [ENTRY_W-1:0]       rdata_raw;
    entry_t                   rd, wr_entry;
    logic [KEY_TIME_W:0]      rem_dbl;
    logic [VAL_W-1:0]         mul_a, mul_b, add_a;
    logic signed [VAL_W:0]    diff;
    logic                     clamp_val;
    logic [AW-1:0]            seg_val;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= KEY_COUNT_W'(1);
        end
        else if (cfg_valid)
        begin
            key_count_reg <= cfg_data;
        end
    end

    // Keys in use, held to the range one to MAX_KEYS.
    always_comb
    begin
        if (key_count_reg == '0)
        begin
            n_next = NW'(1);
        end
        else if (32'(key_count_reg) > MAX_KEYS)
        begin
            n_next = NW'(MAX_KEYS);
        end
        else
        begin
            n_next = NW'(key_count_reg);
        end
    end

    assign wr_entry = '{t: key_time, x: value_x, y: value_y, z: value_z};
    assign ram_we   = cmd.key_wr && (32'(key_index) < MAX_KEYS);

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_ZERO: raddr = '0;
            ADDR_LAST: raddr = AW'(n_reg - NW'(1));
            ADDR_NEXT: raddr = idx_reg + 1'b1;
            default:   raddr = '0;
        endcase
    end

    kvs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(key_index)),
        .wdata (wr_entry),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rd = entry_t'(rdata_raw);

    assign stat.n_one   = (n_reg == NW'(1));
    assign stat.q_lt_rd = (q_reg < rd.t);
    assign stat.div_ok  = (b_reg.t > a_reg.t) && (q_reg >= a_reg.t);

    always_comb
    begin
        case (cmd.clamp_sel)
            CLAMP_OFF: clamp_val = 1'b0;
            CLAMP_ON:  clamp_val = 1'b1;
            CLAMP_NE:  clamp_val = (q_reg != rd.t);
            default:   clamp_val = 1'b0;
        endcase
    end

    always_comb
    begin
        case (cmd.seg_sel)
            SEG_FIRST: seg_val = '0;
            SEG_LAST:  seg_val = AW'(n_reg - NW'(2));
            SEG_SCAN:  seg_val = idx_reg - 1'b1;
            default:   seg_val = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.mul_comp)
            COMP_X:
            begin
                mul_a = a_reg.x;
                mul_b = b_reg.x;
            end
            COMP_Y:
            begin
                mul_a = a_reg.y;
                mul_b = b_reg.y;
            end
            COMP_Z:
            begin
                mul_a = a_reg.z;
                mul_b = b_reg.z;
            end
            default:
            begin
                mul_a = a_reg.x;
                mul_b = b_reg.x;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.add_comp)
            COMP_X:  add_a = a_reg.x;
            COMP_Y:  add_a = a_reg.y;
            COMP_Z:  add_a = a_reg.z;
            default: add_a = a_reg.x;
        endcase
    end

    assign diff    = $signed({mul_b[VAL_W-1], mul_b}) - $signed({mul_a[VAL_W-1], mul_a});
    assign rem_dbl = {rem_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.smp_ld)
        begin
            q_reg <= query_time;
            n_reg <= n_next;
        end
        if (cmd.smp_ld)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.a_ld)
        begin
            a_reg <= rd;
        end
        if (cmd.b_ld)
        begin
            b_reg <= rd;
        end
        if (cmd.clamp_ld)
        begin
            clamp_reg <= clamp_val;
        end
        if (cmd.seg_ld)
        begin
            seg_reg <= seg_val;
        end
        // Restoring division; the remainder stays below the span.
        if (cmd.div_init)
        begin
            rem_reg  <= q_reg - a_reg.t;
            span_reg <= b_reg.t - a_reg.t;
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_dbl >= {1'b0, span_reg})
            begin
                rem_reg <= KEY_TIME_W'(rem_dbl - {1'b0, span_reg});
                quo_reg <= {quo_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= KEY_TIME_W'(rem_dbl);
                quo_reg <= {quo_reg[FRAC_W-2:0], 1'b0};
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= diff * $signed({1'b0, quo_reg});
        end
        // The arithmetic shift by the fraction width floors toward minus infinity.
        if (cmd.add_en)
        begin
            res_reg[cmd.add_comp] <= add_a + prod_reg[FRAC_W+VAL_W-1:FRAC_W];
        end
        if (cmd.out_ld)
        begin
            ox_reg     <= res_reg[COMP_X];
            oy_reg     <= res_reg[COMP_Y];
            oz_reg     <= res_reg[COMP_Z];
            oseg_reg   <= SEG_W'(seg_reg);
            oclamp_reg <= clamp_reg;
        end
    end

    assign out_x   = ox_reg;
    assign out_y   = oy_reg;
    assign out_z   = oz_reg;
    assign segment = oseg_reg;
    assign clamped = oclamp_reg;

endmodule

// ----- hw/rtl/keyframe_vector_sampler_core.sv -----
// A key load is one beat and is taken in any idle cycle. A sample holds the input until its
// result is loaded into the output register, so one sample is in flight at a time. Its time
// is set by the linear key scan over the key memory and the restoring divider. Samples at
// the ends of the track (a single key, a query before the first key, or one at or past the
// last key) skip both. Reset: rst_n clears the controller and sets the key count to one;
// key memory is not cleared.
module keyframe_vector_sampler_core
    import kvs_pkg::*;
#(
    parameter int MAX_KEYS = DEFAULT_MAX_KEYS
) (
    input  logic     clk,
    input  logic     rst_n,
    kvs_req_if.sink  req,
    kvs_res_if.source result,
    kvs_cfg_if.sink  cfg
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The configuration register takes a write on every cycle. Writes must be made only while the
    // block is idle, which the block does not enforce; a sample latches the key count on entry.
    assign cfg.ready = 1'b1;

    // The controller walks one sample through: read key 0, check the two ends of the track,
    // scan forward for the segment, divide for the blend factor, then blend each component.
    kvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the key memory, the segment end registers, the divider, the one
    // shared multiplier and the output register. The output register lets the next beat
    // enter while a finished result still waits on the downstream side.
    kvs_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_valid  (cfg.valid),
        .cfg_data   (cfg.data),
        .key_index  (req.key_index),
        .key_time   (req.key_time),
        .value_x    (req.value_x),
        .value_y    (req.value_y),
        .value_z    (req.value_z),
        .query_time (req.query_time),
        .out_x      (result.out_x),
        .out_y      (result.out_y),
        .out_z      (result.out_z),
        .segment    (result.segment),
        .clamped    (result.clamped)
    );

    // A sample beat moves the controller out of its idle state.
    a_sample_busy : assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.req_type == REQ_SAMPLE) |=> !req.ready)
        else $error("input still ready after a sample beat");

    // The divider and the multiplier never run in the same cycle.
    a_div_mul_excl : assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.div_step && cmd.mul_en))
        else $error("divider and multiplier active together");

    // Keys are written only when a load beat is taken.
    a_key_wr_beat : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.key_wr |-> req.valid && req.ready && (req.req_type == REQ_LOAD))
        else $error("key write without a load beat");

    // The output register is loaded only when it is free or being drained.
    a_out_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> !result.valid || result.ready)
        else $error("pending result overwritten");

endmodule
